FILE: hdl/tfra_pkg.sv
package tfra_pkg;

  localparam int COORD_BITS  = 12;
  localparam int STAGES      = 16;
  localparam int SHIFT_BITS  = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int GUARD_BITS  = 8;
  localparam int INT_FRAC    = 16;
  localparam int OUT_FRAC    = 6;
  localparam int ROUND_SHIFT = INT_FRAC - OUT_FRAC;
  // difference scaled by guard bits, plus gain and growth headroom
  localparam int VW          = COORD_BITS + 1 + GUARD_BITS + 3;
  localparam int ZW          = 26;
  localparam int MW          = VW + 1;
  localparam int THR_BITS    = 14;
  localparam int DELTA_BITS  = 15;
  localparam int NVEC        = 7;

  localparam logic signed [ZW-1:0] QUARTER = ZW'(90 <<< INT_FRAC);
  localparam logic signed [ZW:0]   HALF    = (ZW+1)'(180 <<< INT_FRAC);
  localparam logic signed [ZW:0]   FULL    = (ZW+1)'(360 <<< INT_FRAC);
  localparam logic signed [DELTA_BITS-1:0] LIM = DELTA_BITS'(180 <<< OUT_FRAC);
  localparam logic [THR_BITS-1:0] MIN_ROT_RESET = THR_BITS'(128);

  typedef struct packed {
    logic [COORD_BITS-1:0] prev_first_x;
    logic [COORD_BITS-1:0] prev_first_y;
    logic [COORD_BITS-1:0] prev_second_x;
    logic [COORD_BITS-1:0] prev_second_y;
    logic [COORD_BITS-1:0] curr_first_x;
    logic [COORD_BITS-1:0] curr_first_y;
    logic [COORD_BITS-1:0] curr_second_x;
    logic [COORD_BITS-1:0] curr_second_y;
  } in_word_t;

  typedef struct packed {
    logic signed [DELTA_BITS-1:0] rotation_delta;
    logic                         fingers_swapped;
  } out_word_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  function automatic logic signed [ZW-1:0] atan_lut(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 2949120;   1: r = 1740967;  2: r = 919879;  3: r = 466945;
      4: r = 234379;    5: r = 117304;   6: r = 58666;   7: r = 29335;
      8: r = 14668;     9: r = 7334;     10: r = 3667;   11: r = 1833;
      12: r = 917;      13: r = 458;     14: r = 229;    15: r = 115;
      16: r = 57;       17: r = 29;      18: r = 14;     19: r = 7;
      20: r = 4;        21: r = 2;       22: r = 1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/two_finger_rotation_angle.sv
// Two-finger rotation detector.
// Input: pulse start with the word on cmd while busy is low; busy is tied low,
// so a word may be issued every clock.
// Output: done pulses for one cycle with the word on result; the receiver must
// take it then, there is no back-pressure.
// Pipeline: one front stage for the differences and quadrant fold, one register
// per CORDIC micro-rotation over seven lanes, then sum/angle, delta and rounding
// stages.
// Throughput: one word per cycle; the CORDIC lanes are fully unrolled.
// The crossed-order current vector runs in a lane of its own; its angle is
// picked once the swap decision is known.
// min_rotation is written through cfg_we/cfg_data and resets to 128 (2 deg).
// Reset clears all valid bits; words in flight are dropped.
module two_finger_rotation_angle (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  tfra_pkg::in_word_t            cmd,
  output logic                          done,
  output tfra_pkg::out_word_t           result,
  input  logic                          cfg_we,
  input  logic [tfra_pkg::THR_BITS-1:0] cfg_data
);
  logic [tfra_pkg::THR_BITS-1:0] min_rotation;
  logic                          vld [tfra_pkg::STAGES+1];
  tfra_pkg::vec_t                v   [tfra_pkg::STAGES+1][tfra_pkg::NVEC];
  logic [tfra_pkg::NVEC-1:0]     zr  [tfra_pkg::STAGES+1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rotation <= tfra_pkg::MIN_ROT_RESET;
    end else if (cfg_we) begin
      min_rotation <= cfg_data;
    end
  end

  tfra_front u_front (
    .clk(clk), .rst(rst), .vld_in(start), .w(cmd),
    .vld_out(vld[0]), .v_out(v[0]), .zero_out(zr[0])
  );

  for (genvar i = 0; i < tfra_pkg::STAGES; i++) begin : g_stage
    tfra_cordic_stage u_stage (
      .clk(clk), .rst(rst), .shift(tfra_pkg::SHIFT_BITS'(i)),
      .vld_in(vld[i]), .v_in(v[i]), .swp_in(zr[i]),
      .vld_out(vld[i+1]), .v_out(v[i+1]), .swp_out(zr[i+1])
    );
  end

  tfra_back u_back (
    .clk(clk), .rst(rst), .vld_in(vld[tfra_pkg::STAGES]), .v_in(v[tfra_pkg::STAGES]),
    .zero_in(zr[tfra_pkg::STAGES]), .min_rotation(min_rotation),
    .vld_out(done), .word_out(result)
  );
endmodule

FILE: hdl/tfra_cordic_stage.sv
// one vectoring micro-rotation for all lanes, registered
module tfra_cordic_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [tfra_pkg::SHIFT_BITS-1:0] shift,
  input  logic                 vld_in,
  input  tfra_pkg::vec_t       v_in  [tfra_pkg::NVEC],
  input  logic [tfra_pkg::NVEC-1:0] swp_in,
  output logic                 vld_out,
  output tfra_pkg::vec_t       v_out [tfra_pkg::NVEC],
  output logic [tfra_pkg::NVEC-1:0] swp_out
);
  tfra_pkg::vec_t v_next [tfra_pkg::NVEC];

  always_comb begin
    for (int k = 0; k < tfra_pkg::NVEC; k++) begin
      if (!v_in[k].y[tfra_pkg::VW-1]) begin
        v_next[k].x = v_in[k].x + (v_in[k].y >>> shift);
        v_next[k].y = v_in[k].y - (v_in[k].x >>> shift);
        v_next[k].z = v_in[k].z + tfra_pkg::atan_lut(int'(shift));
      end else begin
        v_next[k].x = v_in[k].x - (v_in[k].y >>> shift);
        v_next[k].y = v_in[k].y + (v_in[k].x >>> shift);
        v_next[k].z = v_in[k].z - tfra_pkg::atan_lut(int'(shift));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
    v_out   <= v_next;
    swp_out <= swp_in;
  end
endmodule

FILE: hdl/tfra_front.sv
// differences, zero marks and quadrant pre-rotation
module tfra_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                vld_in,
  input  tfra_pkg::in_word_t  w,
  output logic                vld_out,
  output tfra_pkg::vec_t      v_out [tfra_pkg::NVEC],
  output logic [tfra_pkg::NVEC-1:0] zero_out
);
  localparam int DW = tfra_pkg::COORD_BITS + 1;
  logic signed [DW-1:0] dx [tfra_pkg::NVEC];
  logic signed [DW-1:0] dy [tfra_pkg::NVEC];
  tfra_pkg::vec_t v_next [tfra_pkg::NVEC];
  logic [tfra_pkg::NVEC-1:0] zero_next;

  function automatic logic signed [DW-1:0] sub(input logic [tfra_pkg::COORD_BITS-1:0] a,
                                                input logic [tfra_pkg::COORD_BITS-1:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  always_comb begin
    // lanes: d00 d11 d01 d10, prev pair, current pair straight, current pair crossed
    dx[0] = sub(w.curr_first_x, w.prev_first_x);   dy[0] = sub(w.curr_first_y, w.prev_first_y);
    dx[1] = sub(w.curr_second_x, w.prev_second_x); dy[1] = sub(w.curr_second_y, w.prev_second_y);
    dx[2] = sub(w.curr_first_x, w.prev_second_x);  dy[2] = sub(w.curr_first_y, w.prev_second_y);
    dx[3] = sub(w.curr_second_x, w.prev_first_x);  dy[3] = sub(w.curr_second_y, w.prev_first_y);
    dx[4] = sub(w.prev_second_x, w.prev_first_x);  dy[4] = sub(w.prev_second_y, w.prev_first_y);
    dx[5] = sub(w.curr_second_x, w.curr_first_x);  dy[5] = sub(w.curr_second_y, w.curr_first_y);
    dx[6] = sub(w.curr_first_x, w.curr_second_x);  dy[6] = sub(w.curr_first_y, w.curr_second_y);
    for (int k = 0; k < tfra_pkg::NVEC; k++) begin
      logic signed [tfra_pkg::VW-1:0] sx, sy;
      sx = tfra_pkg::VW'(dx[k]) <<< tfra_pkg::GUARD_BITS;
      sy = tfra_pkg::VW'(dy[k]) <<< tfra_pkg::GUARD_BITS;
      zero_next[k] = (dx[k] == '0) && (dy[k] == '0);
      if (!sx[tfra_pkg::VW-1]) begin
        v_next[k].x = sx; v_next[k].y = sy; v_next[k].z = '0;
      end else if (!sy[tfra_pkg::VW-1]) begin
        v_next[k].x = sy; v_next[k].y = -sx; v_next[k].z = tfra_pkg::QUARTER;
      end else begin
        v_next[k].x = -sy; v_next[k].y = sx; v_next[k].z = -tfra_pkg::QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
    v_out    <= v_next;
    zero_out <= zero_next;
  end
endmodule

FILE: hdl/tfra_back.sv
// swap decision, angle delta, wrap, rounding, clamp and threshold
module tfra_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           vld_in,
  input  tfra_pkg::vec_t                 v_in [tfra_pkg::NVEC],
  input  logic [tfra_pkg::NVEC-1:0]      zero_in,
  input  logic [tfra_pkg::THR_BITS-1:0]  min_rotation,
  output logic                           vld_out,
  output tfra_pkg::out_word_t            word_out
);
  localparam int ZW = tfra_pkg::ZW;
  localparam int RW = ZW + 1 - tfra_pkg::ROUND_SHIFT + 1;
  localparam int DELTA_BITS_L = tfra_pkg::DELTA_BITS;

  // stage A: magnitude sums and clean angles
  logic                         a_vld, b_vld;
  logic signed [tfra_pkg::MW-1:0] s_straight, s_cross;
  logic signed [ZW-1:0]         a_angp, a_angc, a_angx;
  logic                         b_swp;
  logic signed [ZW:0]           b_delta;
  logic signed [tfra_pkg::VW-1:0] m [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      m[k] = zero_in[k] ? '0 : v_in[k].x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      a_vld <= vld_in;
      b_vld <= a_vld;
    end
    s_straight <= tfra_pkg::MW'(m[0]) + tfra_pkg::MW'(m[1]);
    s_cross    <= tfra_pkg::MW'(m[2]) + tfra_pkg::MW'(m[3]);
    a_angp     <= zero_in[4] ? '0 : v_in[4].z;
    a_angc     <= zero_in[5] ? '0 : v_in[5].z;
    a_angx     <= zero_in[6] ? '0 : v_in[6].z;
  end

  // stage B: take the current angle of the matched order and subtract the previous angle
  logic                 swp;
  logic signed [ZW-1:0] angc_eff;
  logic signed [ZW:0]   d0;
  always_comb begin
    swp = s_cross < s_straight;
    angc_eff = swp ? a_angx : a_angc;
    d0 = (ZW+1)'(angc_eff) - (ZW+1)'(a_angp);
  end
  always_ff @(posedge clk) begin
    b_swp   <= swp;
    b_delta <= d0;
  end

  // wrap into a half turn, round, clamp and drop jitter
  logic signed [ZW+1:0] d1;
  logic signed [ZW+1:0] r_abs;
  logic signed [DELTA_BITS_L-1:0] r;
  logic [RW-1:0] mag;
  logic          neg;
  always_comb begin
    d1 = (ZW+2)'(b_delta);
    if (d1 > (ZW+2)'(tfra_pkg::HALF)) d1 = d1 - (ZW+2)'(tfra_pkg::FULL);
    if (d1 < -(ZW+2)'(tfra_pkg::HALF)) d1 = d1 + (ZW+2)'(tfra_pkg::FULL);
    if (d1 > (ZW+2)'(tfra_pkg::HALF)) d1 = (ZW+2)'(tfra_pkg::HALF);
    if (d1 < -(ZW+2)'(tfra_pkg::HALF)) d1 = -(ZW+2)'(tfra_pkg::HALF);
    neg   = d1[ZW+1];
    r_abs = neg ? -d1 : d1;
    mag   = RW'((r_abs + (ZW+2)'(1 <<< (tfra_pkg::ROUND_SHIFT - 1))) >>>
                tfra_pkg::ROUND_SHIFT);
    if (mag > RW'(tfra_pkg::LIM)) mag = RW'(tfra_pkg::LIM);
    if (mag < RW'(min_rotation)) mag = '0;
    r = neg ? -DELTA_BITS_L'(mag) : DELTA_BITS_L'(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= b_vld;
    end
    word_out.rotation_delta  <= r;
    word_out.fingers_swapped <= b_swp;
  end
endmodule

FILE: hdl/tfra_checker.sv
module tfra_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input tfra_pkg::out_word_t result
);
  localparam int LAT = tfra_pkg::STAGES + 4;

  a_no_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("done without a word");
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.rotation_delta <= tfra_pkg::LIM &&
              result.rotation_delta >= -tfra_pkg::LIM))
    else $error("rotation out of range");
endmodule

bind two_finger_rotation_angle tfra_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);
